// File: rtl/core/bfgl_pkg.sv
// Shared types and constants for the bitmap font glyph layout block.
// Has no dependencies; every other file of the block imports it.

package bfgl_pkg;

    // Function codes carried by an input request.
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_CURSOR = 2'd1;
    localparam logic [1:0] FUNC_CHAR   = 2'd2;

    // Control characters handled by the layout logic.
    localparam logic [7:0] CODE_LF = 8'd10;
    localparam logic [7:0] CODE_CR = 8'd13;

    // Configuration register map: index taken from paddr[3:2].
    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_FIRST_CODE  = 2'd0;
    localparam logic [1:0] REG_LAST_CODE   = 2'd1;
    localparam logic [1:0] REG_BREAK_CODE  = 2'd2;
    localparam logic [1:0] REG_LINE_HEIGHT = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_FIRST_CODE  = 8'd0;
    localparam logic [7:0] RST_LAST_CODE   = 8'd255;
    localparam logic [7:0] RST_BREAK_CODE  = 8'd32;
    localparam logic [7:0] RST_LINE_HEIGHT = 8'd16;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [7:0] first_code;
        logic [7:0] last_code;
        logic [7:0] break_code;
        logic [7:0] line_height;
    } cfg_t;

    // Request held between the lookup stage and the layout stage.
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  code;
        logic [7:0]  load_width;
        logic [7:0]  load_height;
        logic        idx_zero;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
    } item_t;

endpackage

// File: rtl/core/bfgl_cfg_regs.sv
// APB-style configuration registers of the glyph layout block.
// Depends on bfgl_pkg for the register map, reset values and cfg_t.

module bfgl_cfg_regs
    import bfgl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                REG_FIRST_CODE:  cfg_next.first_code  = pwdata[7:0];
                REG_LAST_CODE:   cfg_next.last_code   = pwdata[7:0];
                REG_BREAK_CODE:  cfg_next.break_code  = pwdata[7:0];
                REG_LINE_HEIGHT: cfg_next.line_height = pwdata[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_code  <= RST_FIRST_CODE;
            cfg_reg.last_code   <= RST_LAST_CODE;
            cfg_reg.break_code  <= RST_BREAK_CODE;
            cfg_reg.line_height <= RST_LINE_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back of the selected register.
    always_comb
    begin
        case (paddr[3:2])
            REG_FIRST_CODE:  prdata = {24'd0, cfg_reg.first_code};
            REG_LAST_CODE:   prdata = {24'd0, cfg_reg.last_code};
            REG_BREAK_CODE:  prdata = {24'd0, cfg_reg.break_code};
            REG_LINE_HEIGHT: prdata = {24'd0, cfg_reg.line_height};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/core/bfgl_fetch.sv
// Input stage: code substitution, glyph table write and registered lookup,
// atlas cell position lookup. Depends on bfgl_pkg for cfg_t and item_t.

module bfgl_fetch
    import bfgl_pkg::*;
#(
    parameter int TABLE_DEPTH   = 256,
    parameter int ATLAS_COLUMNS = 16,
    localparam int COL_W        = (ATLAS_COLUMNS > 1) ? $clog2(ATLAS_COLUMNS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       func,
    input  logic [7:0]       glyph_index,
    input  logic [7:0]       glyph_width,
    input  logic [7:0]       glyph_height,
    input  logic [15:0]      origin_x,
    input  logic [15:0]      origin_y,
    input  logic [7:0]       char_code,
    input  logic             s1_go,
    output logic             s1_valid,
    output item_t            s1_req,
    output logic [7:0]       s1_glyph_w,
    output logic [7:0]       s1_glyph_h,
    output logic [COL_W-1:0] s1_col,
    output logic [7:0]       s1_row
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int PE_W = COL_W + 8;

    // Row and column of every glyph position, built without division.
    function automatic logic [256*PE_W-1:0] build_pos_table();
        logic [256*PE_W-1:0] tbl;
        int col;
        int row;
        tbl = '0;
        col = 0;
        row = 0;
        for (int i = 0; i < 256; i++)
        begin
            tbl[i*PE_W +: PE_W] = {8'(row), COL_W'(col)};
            col = col + 1;
            if (col == ATLAS_COLUMNS)
            begin
                col = 0;
                row = row + 1;
            end
        end
        return tbl;
    endfunction

    localparam logic [256*PE_W-1:0] POS_TABLE = build_pos_table();

    logic [15:0]          glyph_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] entry_valid_reg;
    logic [TABLE_DEPTH-1:0] entry_valid_next;

    logic                 accept;
    logic [7:0]           code;
    logic [7:0]           gpos;
    logic [PE_W-1:0]      pos_entry;
    logic [8:0]           wr_addr_full;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic                 in_table;
    item_t                req_next;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    item_t                s1_req_reg;
    logic [15:0]          rd_data_reg;
    logic                 hit_reg;
    logic [COL_W-1:0]     col_reg;
    logic [7:0]           row_reg;

    assign in_stall = s1_valid_reg && !s1_go;
    assign accept   = in_valid && !in_stall;

    // Replace codes outside the font by the break code.
    always_comb
    begin
        if ((char_code < cfg.first_code) || (char_code > cfg.last_code))
        begin
            code = cfg.break_code;
        end
        else
        begin
            code = char_code;
        end
    end

    assign gpos      = code - cfg.first_code;
    assign pos_entry = POS_TABLE[gpos*PE_W +: PE_W];
    assign rd_addr   = code[AW-1:0];
    assign in_table  = {1'b0, code} < 9'(TABLE_DEPTH);

    // Glyph table write for load requests; entries past the table are dropped.
    assign wr_addr_full = {1'b0, glyph_index} + {1'b0, cfg.first_code};
    assign wr_en        = accept && (func == FUNC_LOAD)
                          && (wr_addr_full < 9'(TABLE_DEPTH));
    assign wr_addr      = wr_addr_full[AW-1:0];

    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        if (wr_en)
        begin
            entry_valid_next[wr_addr] = 1'b1;
        end
    end

    always_comb
    begin
        req_next.func        = func;
        req_next.code        = code;
        req_next.load_width  = glyph_width;
        req_next.load_height = glyph_height;
        req_next.idx_zero    = (glyph_index == 8'd0);
        req_next.origin_x    = origin_x;
        req_next.origin_y    = origin_y;
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Control state: stage occupancy and table valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            entry_valid_reg <= entry_valid_next;
        end
    end

    // Glyph memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            glyph_mem[wr_addr] <= {glyph_width, glyph_height};
        end
        if (accept)
        begin
            rd_data_reg <= glyph_mem[rd_addr];
        end
    end

    // Stage register for the request and its lookups.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= req_next;
            hit_reg    <= in_table && entry_valid_reg[rd_addr];
            col_reg    <= pos_entry[COL_W-1:0];
            row_reg    <= pos_entry[PE_W-1:COL_W];
        end
    end

    assign s1_valid   = s1_valid_reg;
    assign s1_req     = s1_req_reg;
    assign s1_glyph_w = hit_reg ? rd_data_reg[15:8] : 8'd0;
    assign s1_glyph_h = hit_reg ? rd_data_reg[7:0]  : 8'd0;
    assign s1_col     = col_reg;
    assign s1_row     = row_reg;

endmodule

// File: rtl/core/bfgl_layout.sv
// Layout stage: cursor and cell size state, atlas offsets, result register.
// Depends on bfgl_pkg for cfg_t, item_t, function and character codes.

module bfgl_layout
    import bfgl_pkg::*;
#(
    parameter int ATLAS_COLUMNS = 16,
    localparam int COL_W        = (ATLAS_COLUMNS > 1) ? $clog2(ATLAS_COLUMNS) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              s1_valid,
    input  item_t             s1_req,
    input  logic [7:0]        s1_glyph_w,
    input  logic [7:0]        s1_glyph_h,
    input  logic [COL_W-1:0]  s1_col,
    input  logic [7:0]        s1_row,
    output logic              s1_go,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [15:0] dst_x,
    output logic signed [15:0] dst_y,
    output logic [7:0]        rect_width,
    output logic [7:0]        rect_height,
    output logic [11:0]       src_x,
    output logic [11:0]       src_y
);

    logic [15:0] cursor_x_reg, cursor_x_next;
    logic [15:0] cursor_y_reg, cursor_y_next;
    logic [15:0] line_x_reg, line_x_next;
    logic [7:0]  cell_w_reg, cell_w_next;
    logic [7:0]  cell_h_reg, cell_h_next;
    logic        out_valid_reg, out_valid_next;

    logic [15:0] dst_x_reg, dst_y_reg;
    logic [7:0]  rect_w_reg, rect_h_reg;
    logic [11:0] src_x_reg, src_y_reg;

    logic        is_char;
    logic        emits;
    logic        load_go;
    logic [7:0]  cell_w_base;
    logic [7:0]  cell_h_base;
    logic [COL_W+11:0] prod_x;
    logic [15:0] prod_y;

    assign is_char = (s1_req.func == FUNC_CHAR);
    assign emits   = is_char && (s1_req.code != CODE_CR) && (s1_req.code != CODE_LF);
    assign s1_go   = s1_valid && (!emits || !out_valid_reg || !out_stall);
    assign load_go = s1_go && (s1_req.func == FUNC_LOAD);

    // Running maxima of the loaded glyph sizes; index zero restarts them.
    assign cell_w_base = s1_req.idx_zero ? 8'd0 : cell_w_reg;
    assign cell_h_base = s1_req.idx_zero ? 8'd0 : cell_h_reg;

    always_comb
    begin
        cell_w_next = cell_w_reg;
        cell_h_next = cell_h_reg;
        if (load_go)
        begin
            cell_w_next = (s1_req.load_width > cell_w_base) ? s1_req.load_width
                                                            : cell_w_base;
            cell_h_next = (s1_req.load_height > cell_h_base) ? s1_req.load_height
                                                             : cell_h_base;
        end
    end

    // Cursor updates for cursor, line feed and drawn characters.
    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        line_x_next   = line_x_reg;
        if (s1_go)
        begin
            case (s1_req.func)
                FUNC_CURSOR:
                begin
                    cursor_x_next = s1_req.origin_x;
                    cursor_y_next = s1_req.origin_y;
                    line_x_next   = s1_req.origin_x;
                end
                FUNC_CHAR:
                begin
                    if (s1_req.code == CODE_LF)
                    begin
                        cursor_x_next = line_x_reg;
                        cursor_y_next = cursor_y_reg + {8'd0, cfg.line_height};
                    end
                    else if (s1_req.code != CODE_CR)
                    begin
                        cursor_x_next = cursor_x_reg + {8'd0, s1_glyph_w};
                    end
                end
                default:
                begin
                    cursor_x_next = cursor_x_reg;
                end
            endcase
        end
    end

    // Atlas source offsets of the glyph cell.
    assign prod_x = (COL_W+12)'(s1_col) * (COL_W+12)'(cell_w_reg);
    assign prod_y = {8'd0, s1_row} * {8'd0, cell_h_reg};

    always_comb
    begin
        if (s1_go && emits)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= 16'd0;
            cursor_y_reg  <= 16'd0;
            line_x_reg    <= 16'd0;
            cell_w_reg    <= 8'd0;
            cell_h_reg    <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            line_x_reg    <= line_x_next;
            cell_w_reg    <= cell_w_next;
            cell_h_reg    <= cell_h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result register, loaded when a drawn glyph leaves the stage.
    always_ff @(posedge clk)
    begin
        if (s1_go && emits)
        begin
            dst_x_reg  <= cursor_x_reg;
            dst_y_reg  <= cursor_y_reg;
            rect_w_reg <= s1_glyph_w;
            rect_h_reg <= s1_glyph_h;
            src_x_reg  <= prod_x[11:0];
            src_y_reg  <= prod_y[11:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign dst_x       = dst_x_reg;
    assign dst_y       = dst_y_reg;
    assign rect_width  = rect_w_reg;
    assign rect_height = rect_h_reg;
    assign src_x       = src_x_reg;
    assign src_y       = src_y_reg;

endmodule

// File: rtl/core/bitmap_font_glyph_layout.sv
// Top level of the bitmap font glyph layout block.
// Depends on bfgl_pkg, bfgl_cfg_regs, bfgl_fetch and bfgl_layout.
//
// Usage: requests enter on the in_ channel (valid/stall) carrying func and
// the load, cursor and character fields. A load request stores a glyph size
// and updates the atlas cell size, a cursor request sets the text origin, and
// a character request lays out one glyph. Each drawn glyph leaves as one
// result on the out_ channel with its screen and atlas rectangles. Carriage
// return, line feed and load or cursor requests give no result.
// Throughput is one request per cycle while the receiver does not stall. The
// glyph memory read and cell position lookup fill the stage register, and the
// current cursor and the atlas multiplies fill the result register.
// When the receiver stalls, the result register holds its result and one
// more request waits in the stage register; in_stall rises only when that
// request also needs the result register.
// Reset clears the cursor, the cell size and the glyph table valid bits and
// sets the configuration registers to their reset values at once; no clearing
// pass is needed. Configuration registers are to be written by the user over
// the APB port only while idle; the block itself does not enforce it.

module bitmap_font_glyph_layout
    import bfgl_pkg::*;
#(
    parameter int TABLE_DEPTH   = 256,
    parameter int ATLAS_COLUMNS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            func,
    input  logic [7:0]            glyph_index,
    input  logic [7:0]            glyph_width,
    input  logic [7:0]            glyph_height,
    input  logic signed [15:0]    origin_x,
    input  logic signed [15:0]    origin_y,
    input  logic [7:0]            char_code,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [15:0]    dst_x,
    output logic signed [15:0]    dst_y,
    output logic [7:0]            rect_width,
    output logic [7:0]            rect_height,
    output logic [11:0]           src_x,
    output logic [11:0]           src_y
);

    localparam int COL_W = (ATLAS_COLUMNS > 1) ? $clog2(ATLAS_COLUMNS) : 1;

    cfg_t             cfg;
    logic             s1_go;
    logic             s1_valid;
    item_t            s1_req;
    logic [7:0]       s1_glyph_w;
    logic [7:0]       s1_glyph_h;
    logic [COL_W-1:0] s1_col;
    logic [7:0]       s1_row;

    // Configuration registers.
    bfgl_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Table access and position lookup.
    bfgl_fetch #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .ATLAS_COLUMNS (ATLAS_COLUMNS)
    ) u_fetch (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .glyph_index  (glyph_index),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .char_code    (char_code),
        .s1_go        (s1_go),
        .s1_valid     (s1_valid),
        .s1_req       (s1_req),
        .s1_glyph_w   (s1_glyph_w),
        .s1_glyph_h   (s1_glyph_h),
        .s1_col       (s1_col),
        .s1_row       (s1_row)
    );

    // Cursor state and result register.
    bfgl_layout #(
        .ATLAS_COLUMNS (ATLAS_COLUMNS)
    ) u_layout (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .s1_valid    (s1_valid),
        .s1_req      (s1_req),
        .s1_glyph_w  (s1_glyph_w),
        .s1_glyph_h  (s1_glyph_h),
        .s1_col      (s1_col),
        .s1_row      (s1_row),
        .s1_go       (s1_go),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .dst_x       (dst_x),
        .dst_y       (dst_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .src_x       (src_x),
        .src_y       (src_y)
    );

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the bitmap font glyph layout block.
// Depends on bfgl_pkg and bitmap_font_glyph_layout; predicts every glyph
// rectangle and checks each result against it.
`timescale 1ns / 100ps

module testbench;
    import bfgl_pkg::*;

    localparam int TABLE_DEPTH   = 256;
    localparam int ATLAS_COLUMNS = 16;
    localparam int IDLE_PERCENT  = 38;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_COUNT   = 6;
    localparam int PHASE_ITEMS   = 85;

    // Function code that the block ignores.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  glyph_index;
        logic [7:0]  glyph_width;
        logic [7:0]  glyph_height;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [7:0]  char_code;
    } request_t;

    typedef struct packed {
        logic [15:0] dst_x;
        logic [15:0] dst_y;
        logic [7:0]  rect_width;
        logic [7:0]  rect_height;
        logic [11:0] src_x;
        logic [11:0] src_y;
    } glyph_rect_t;

    typedef enum {ROW_REQUEST, ROW_CONFIG} row_kind_e;
    typedef enum {CHECK_MODEL, CHECK_TYPED, CHECK_NONE} check_mode_e;

    typedef struct {
        row_kind_e   kind;
        check_mode_e check;
        request_t    req;
        logic [1:0]  reg_sel;
        logic [7:0]  reg_val;
        glyph_rect_t typed;
    } stim_row_t;

    localparam glyph_rect_t NO_RECT = '0;

    // Block ports.
    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            func;
    logic [7:0]            glyph_index;
    logic [7:0]            glyph_width;
    logic [7:0]            glyph_height;
    logic [15:0]           origin_x;
    logic [15:0]           origin_y;
    logic [7:0]            char_code;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [15:0]    dst_x;
    logic signed [15:0]    dst_y;
    logic [7:0]            rect_width;
    logic [7:0]            rect_height;
    logic [11:0]           src_x;
    logic [11:0]           src_y;

    // Predicted state of the layout engine.
    logic [7:0]  cfg_first;
    logic [7:0]  cfg_last;
    logic [7:0]  cfg_break;
    logic [7:0]  cfg_lheight;
    logic [7:0]  width_mem [TABLE_DEPTH];
    logic [7:0]  height_mem [TABLE_DEPTH];
    logic [7:0]  cell_w;
    logic [7:0]  cell_h;
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic [15:0] line_x;

    // Glyph rectangles predicted but not yet seen on the output.
    glyph_rect_t rects_due [$];
    stim_row_t   directed_rows [$];

    int mismatches;
    int cycle_count;
    bit quiet_sender;
    bit quiet_receiver;
    bit hold_request;
    int hold_left;

    bitmap_font_glyph_layout dut (.*);

    // Clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Predict the effect of one accepted request; returns 1 with the
    // rectangle when a glyph is drawn.
    function automatic bit layout_predict(input request_t r, output glyph_rect_t rect);
        logic [8:0] addr;
        logic [7:0] code;
        logic [7:0] gpos;
        logic [7:0] gw;
        logic [7:0] gh;
        int         col;
        int         row;
        layout_predict = 1'b0;
        rect = NO_RECT;
        case (r.func)
            FUNC_LOAD:
            begin
                addr = {1'b0, r.glyph_index} + {1'b0, cfg_first};
                if (r.glyph_index == 8'd0)
                begin
                    cell_w = 8'd0;
                    cell_h = 8'd0;
                end
                if (r.glyph_width > cell_w)
                    cell_w = r.glyph_width;
                if (r.glyph_height > cell_h)
                    cell_h = r.glyph_height;
                // Entries past the end of the table are dropped.
                if (addr < TABLE_DEPTH)
                begin
                    width_mem[addr[7:0]]  = r.glyph_width;
                    height_mem[addr[7:0]] = r.glyph_height;
                end
            end
            FUNC_CURSOR:
            begin
                cur_x  = r.origin_x;
                cur_y  = r.origin_y;
                line_x = r.origin_x;
            end
            FUNC_CHAR:
            begin
                code = r.char_code;
                // Codes outside the font take the break code, which may
                // itself be a control character.
                if (code < cfg_first || code > cfg_last)
                    code = cfg_break;
                if (code == CODE_LF)
                begin
                    cur_x = line_x;
                    cur_y = cur_y + {8'd0, cfg_lheight};
                end
                else if (code != CODE_CR)
                begin
                    gw   = width_mem[code];
                    gh   = height_mem[code];
                    gpos = code - cfg_first;
                    col  = gpos % ATLAS_COLUMNS;
                    row  = gpos / ATLAS_COLUMNS;
                    rect.dst_x       = cur_x;
                    rect.dst_y       = cur_y;
                    rect.rect_width  = gw;
                    rect.rect_height = gh;
                    rect.src_x       = 12'(col * cell_w);
                    rect.src_y       = 12'(row * cell_h);
                    cur_x = cur_x + {8'd0, gw};
                    layout_predict = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Request builders; fields that the function ignores stay random.
    function automatic request_t random_request();
        request_t r;
        r.func         = 2'($urandom_range(0, 3));
        r.glyph_index  = 8'($urandom);
        r.glyph_width  = 8'($urandom);
        r.glyph_height = 8'($urandom);
        r.origin_x     = 16'($urandom);
        r.origin_y     = 16'($urandom);
        r.char_code    = 8'($urandom);
        return r;
    endfunction

    function automatic request_t load_req(input logic [7:0] idx, input logic [7:0] w,
                                          input logic [7:0] h);
        request_t r;
        r = random_request();
        r.func         = FUNC_LOAD;
        r.glyph_index  = idx;
        r.glyph_width  = w;
        r.glyph_height = h;
        return r;
    endfunction

    function automatic request_t cursor_req(input logic [15:0] x, input logic [15:0] y);
        request_t r;
        r = random_request();
        r.func     = FUNC_CURSOR;
        r.origin_x = x;
        r.origin_y = y;
        return r;
    endfunction

    function automatic request_t char_req(input logic [7:0] ch);
        request_t r;
        r = random_request();
        r.func      = FUNC_CHAR;
        r.char_code = ch;
        return r;
    endfunction

    function automatic stim_row_t request_row(input request_t r, input check_mode_e check,
                                              input glyph_rect_t typed);
        stim_row_t row;
        row.kind    = ROW_REQUEST;
        row.check   = check;
        row.req     = r;
        row.reg_sel = REG_FIRST_CODE;
        row.reg_val = 8'd0;
        row.typed   = typed;
        return row;
    endfunction

    function automatic stim_row_t config_row(input logic [1:0] sel, input logic [7:0] val);
        stim_row_t row;
        row = request_row(random_request(), CHECK_MODEL, NO_RECT);
        row.kind    = ROW_CONFIG;
        row.reg_sel = sel;
        row.reg_val = val;
        return row;
    endfunction

    // Offer one request, with random gaps, until the block accepts it,
    // then record what it should produce.
    task automatic issue_request(input request_t r, input check_mode_e check,
                                 input glyph_rect_t typed);
        glyph_rect_t rect;
        bit          drawn;
        @(negedge clk);
        while (!quiet_sender && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        func         <= r.func;
        glyph_index  <= r.glyph_index;
        glyph_width  <= r.glyph_width;
        glyph_height <= r.glyph_height;
        origin_x     <= r.origin_x;
        origin_y     <= r.origin_y;
        char_code    <= r.char_code;
        do
            @(posedge clk);
        while (in_stall);
        drawn = layout_predict(r, rect);
        case (check)
            CHECK_TYPED: rects_due.push_back(typed);
            CHECK_NONE:
            begin
            end
            default:
            begin
                if (drawn)
                    rects_due.push_back(rect);
            end
        endcase
    endtask

    // Stop offering requests and wait until the block has gone quiet.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (rects_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic write_register(input logic [1:0] sel, input logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({sel, 2'b00});
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_FIRST_CODE:  cfg_first   = value;
            REG_LAST_CODE:   cfg_last    = value;
            REG_BREAK_CODE:  cfg_break   = value;
            default:         cfg_lheight = value;
        endcase
    endtask

    task automatic configure(input logic [7:0] first, input logic [7:0] last,
                             input logic [7:0] brk, input logic [7:0] lheight);
        settle();
        write_register(REG_FIRST_CODE, first);
        write_register(REG_LAST_CODE, last);
        write_register(REG_BREAK_CODE, brk);
        write_register(REG_LINE_HEIGHT, lheight);
    endtask

    // Receiver: random stalls, a calm stretch, and one long hold-off.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                out_stall    <= 1'b1;
            end
            else if (quiet_receiver)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Compare each accepted result with the oldest predicted rectangle.
    initial
    begin
        glyph_rect_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (rects_due.size() == 0)
                begin
                    $error("unexpected result at dst %0d,%0d", dst_x, dst_y);
                    mismatches++;
                end
                else
                begin
                    want = rects_due.pop_front();
                    if (dst_x !== want.dst_x)
                    begin
                        $error("dst_x: expected %0d, got %0d", $signed(want.dst_x), dst_x);
                        mismatches++;
                    end
                    if (dst_y !== want.dst_y)
                    begin
                        $error("dst_y: expected %0d, got %0d", $signed(want.dst_y), dst_y);
                        mismatches++;
                    end
                    if (rect_width !== want.rect_width)
                    begin
                        $error("rect_width: expected %0d, got %0d", want.rect_width,
                               rect_width);
                        mismatches++;
                    end
                    if (rect_height !== want.rect_height)
                    begin
                        $error("rect_height: expected %0d, got %0d", want.rect_height,
                               rect_height);
                        mismatches++;
                    end
                    if (src_x !== want.src_x)
                    begin
                        $error("src_x: expected %0d, got %0d", want.src_x, src_x);
                        mismatches++;
                    end
                    if (src_y !== want.src_y)
                    begin
                        $error("src_y: expected %0d, got %0d", want.src_y, src_y);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Main sequence: directed table, then random text phases.
    initial
    begin
        request_t   r;
        int         pick;
        int         nload;
        logic [7:0] f;
        logic [7:0] l;
        logic [7:0] b;
        logic [7:0] lh;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        func           = FUNC_LOAD;
        glyph_index    = '0;
        glyph_width    = '0;
        glyph_height   = '0;
        origin_x       = '0;
        origin_y       = '0;
        char_code      = '0;
        mismatches     = 0;
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        hold_request   = 1'b0;
        hold_left      = 0;

        cfg_first   = RST_FIRST_CODE;
        cfg_last    = RST_LAST_CODE;
        cfg_break   = RST_BREAK_CODE;
        cfg_lheight = RST_LINE_HEIGHT;
        foreach (width_mem[i])
        begin
            width_mem[i]  = 8'd0;
            height_mem[i] = 8'd0;
        end
        cell_w = 8'd0;
        cell_h = 8'd0;
        cur_x  = 16'd0;
        cur_y  = 16'd0;
        line_x = 16'd0;

        // Directed rows: reset state, extremes, restart of the cell size,
        // dropped loads, codes outside the font and control characters.
        directed_rows.push_back(request_row(char_req(8'd65), CHECK_TYPED,
                                            '{16'd0, 16'd0, 8'd0, 8'd0, 12'd0, 12'd0}));
        directed_rows.push_back(request_row(char_req(CODE_LF), CHECK_NONE, NO_RECT));
        directed_rows.push_back(request_row(char_req(8'd65), CHECK_TYPED,
                                            '{16'd0, 16'd16, 8'd0, 8'd0, 12'd0, 12'd0}));
        directed_rows.push_back(request_row(char_req(CODE_CR), CHECK_NONE, NO_RECT));
        directed_rows.push_back(request_row(load_req(8'd0, 8'd255, 8'd255), CHECK_MODEL,
                                            NO_RECT));
        directed_rows.push_back(request_row(load_req(8'd65, 8'd8, 8'd12), CHECK_MODEL,
                                            NO_RECT));
        directed_rows.push_back(request_row(load_req(8'd255, 8'd255, 8'd1), CHECK_MODEL,
                                            NO_RECT));
        directed_rows.push_back(request_row(cursor_req(16'h8000, 16'h7fff), CHECK_MODEL,
                                            NO_RECT));
        directed_rows.push_back(request_row(char_req(8'd65), CHECK_MODEL, NO_RECT));
        directed_rows.push_back(request_row(char_req(8'd255), CHECK_MODEL, NO_RECT));
        directed_rows.push_back(request_row(char_req(CODE_LF), CHECK_MODEL, NO_RECT));
        directed_rows.push_back(request_row(char_req(8'd255), CHECK_MODEL, NO_RECT));
        r = random_request();
        r.func = FUNC_UNUSED;
        directed_rows.push_back(request_row(r, CHECK_NONE, NO_RECT));
        directed_rows.push_back(request_row(load_req(8'd0, 8'd1, 8'd2), CHECK_MODEL,
                                            NO_RECT));
        directed_rows.push_back(request_row(char_req(8'd0), CHECK_MODEL, NO_RECT));
        directed_rows.push_back(config_row(REG_FIRST_CODE, 8'd40));
        directed_rows.push_back(config_row(REG_LAST_CODE, 8'd100));
        directed_rows.push_back(config_row(REG_BREAK_CODE, CODE_LF));
        directed_rows.push_back(config_row(REG_LINE_HEIGHT, 8'd255));
        directed_rows.push_back(request_row(cursor_req(16'h7fff, 16'hffff), CHECK_MODEL,
                                            NO_RECT));
        directed_rows.push_back(request_row(load_req(8'd250, 8'd7, 8'd7), CHECK_MODEL,
                                            NO_RECT));
        directed_rows.push_back(request_row(load_req(8'd0, 8'd3, 8'd3), CHECK_MODEL,
                                            NO_RECT));
        directed_rows.push_back(request_row(char_req(8'd40), CHECK_MODEL, NO_RECT));
        directed_rows.push_back(request_row(char_req(8'd39), CHECK_MODEL, NO_RECT));
        directed_rows.push_back(request_row(char_req(8'd101), CHECK_MODEL, NO_RECT));
        directed_rows.push_back(request_row(char_req(8'd40), CHECK_MODEL, NO_RECT));
        directed_rows.push_back(config_row(REG_BREAK_CODE, CODE_CR));
        directed_rows.push_back(request_row(char_req(8'd0), CHECK_NONE, NO_RECT));
        directed_rows.push_back(config_row(REG_BREAK_CODE, 8'd5));
        directed_rows.push_back(request_row(char_req(8'd255), CHECK_MODEL, NO_RECT));
        directed_rows.push_back(config_row(REG_FIRST_CODE, 8'd0));
        directed_rows.push_back(config_row(REG_LAST_CODE, 8'd0));
        directed_rows.push_back(config_row(REG_BREAK_CODE, 8'd0));
        directed_rows.push_back(config_row(REG_LINE_HEIGHT, 8'd0));
        directed_rows.push_back(request_row(char_req(8'd0), CHECK_MODEL, NO_RECT));
        directed_rows.push_back(request_row(char_req(8'd255), CHECK_MODEL, NO_RECT));

        // Hold reset, then release it away from the rising edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
            begin
                settle();
                write_register(directed_rows[i].reg_sel, directed_rows[i].reg_val);
            end
            else
                issue_request(directed_rows[i].req, directed_rows[i].check,
                              directed_rows[i].typed);
        end

        // Random text phases, each under its own font configuration.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            f  = 8'($urandom);
            l  = 8'($urandom);
            b  = 8'($urandom);
            lh = 8'($urandom);
            case (phase)
                0:
                begin
                    f  = RST_FIRST_CODE;
                    l  = RST_LAST_CODE;
                    b  = RST_BREAK_CODE;
                    lh = RST_LINE_HEIGHT;
                end
                1:
                begin
                    f = 8'd32;
                    l = 8'd126;
                    b = 8'd63;
                end
                3:
                begin
                    f  = 8'd255;
                    l  = 8'd255;
                    b  = 8'd255;
                    lh = 8'd255;
                end
                default:
                begin
                end
            endcase
            configure(f, l, b, lh);

            // First phase runs without any idling; the second fills the
            // block behind a long receiver hold-off.
            quiet_sender   = (phase <= 1);
            quiet_receiver = (phase == 0);
            if (phase == 1)
                hold_request = 1'b1;

            // Font load from entry zero, then a cursor, then text.
            nload = $urandom_range(4, 40);
            for (int i = 0; i < nload; i++)
                issue_request(load_req(8'(i), 8'($urandom), 8'($urandom)), CHECK_MODEL,
                              NO_RECT);
            issue_request(cursor_req(16'($urandom), 16'($urandom)), CHECK_MODEL, NO_RECT);

            for (int n = nload + 1; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    if (cfg_first <= cfg_last)
                        r = char_req(8'(cfg_first + $urandom_range(0, cfg_last - cfg_first)));
                    else
                        r = char_req(8'($urandom));
                end
                else if (pick < 70)
                    r = char_req(CODE_LF);
                else if (pick < 75)
                    r = char_req(CODE_CR);
                else if (pick < 82)
                    r = char_req(8'($urandom));
                else if (pick < 88)
                    r = cursor_req(16'($urandom), 16'($urandom));
                else if (pick < 94)
                    r = load_req(8'($urandom), 8'($urandom), 8'($urandom));
                else
                    r = random_request();
                issue_request(r, CHECK_MODEL, NO_RECT);
            end
        end

        settle();
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
